// ----- rtl/pidf_pkg.sv -----
package pidf_pkg;

   localparam int ID_W     = 22;
   localparam int RIGHTS_W = 21;
   localparam int CNT_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [2:0] FN_PROTECT   = 3'd0;
   localparam logic [2:0] FN_UNPROTECT = 3'd1;
   localparam logic [2:0] FN_ADD_TRUST = 3'd2;
   localparam logic [2:0] FN_HANDLE    = 3'd3;
   localparam logic [2:0] FN_MEMORY    = 3'd4;
   localparam logic [2:0] FN_THREAD    = 3'd5;
   localparam logic [2:0] FN_IMAGE     = 3'd6;
   localparam logic [2:0] FN_EXIT      = 3'd7;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DENIED = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GUARD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK  = 1'd1;

   localparam logic [RIGHTS_W-1:0] MASK_RESET = 21'h00087B;

   typedef struct packed {
      logic [2:0]          func;
      logic [ID_W-1:0]     target_pid;
      logic [ID_W-1:0]     caller_pid;
      logic [RIGHTS_W-1:0] access_rights;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             target_protected;
      logic [7:0]       entry_slot;
      logic [CNT_W-1:0] entry_denied;
      logic [CNT_W-1:0] entry_images;
      logic [CNT_W-1:0] entry_threads;
      logic [CNT_W-1:0] total_handle_checks;
      logic [CNT_W-1:0] total_handle_denied;
      logic [CNT_W-1:0] mem_checks_total;
      logic [CNT_W-1:0] mem_denied_total;
   } rsp_type;

   // request as classified by the front end
   typedef struct packed {
      req_type req;
      logic    tgt_zero;
      logic    self_trust;
   } cls_type;

endpackage

// ----- rtl/pidf_ram.sv -----
module pidf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/pidf_front.sv -----
module pidf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pidf_pkg::req_type req_data,
   output logic              q_valid,
   output pidf_pkg::cls_type q_data,
   input  logic              q_pop
);
   import pidf_pkg::*;

   cls_type    q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cls_type    cls;
   logic       push;

   always_comb begin
      cls.req        = req_data;
      cls.tgt_zero   = (req_data.target_pid == '0);
      cls.self_trust = (req_data.caller_pid == req_data.target_pid) ||
                       (req_data.caller_pid == ID_W'(0)) ||
                       (req_data.caller_pid == ID_W'(1));
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end
endmodule

// ----- rtl/pidf_back.sv -----
module pidf_back #(
   parameter int TABLE_DEPTH = 256,
   parameter int TRUST_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  pidf_pkg::cls_type                   q_data,
   output logic                                q_pop,
   input  logic                                csr_write_enable,
   input  logic [pidf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pidf_pkg::RIGHTS_W-1:0]       csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pidf_pkg::rsp_type                   rsp_data
);
   import pidf_pkg::*;

   localparam int SW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int UW  = $clog2(TABLE_DEPTH + 1);
   localparam int TW  = $clog2(TRUST_DEPTH + 1);
   localparam int TIW = (TRUST_DEPTH > 1) ? $clog2(TRUST_DEPTH) : 1;
   localparam int TDEPTH = TABLE_DEPTH * (2 ** TIW);
   localparam int TAW = SW + TIW;

   typedef struct packed {
      logic [ID_W-1:0]  pid;
      logic [TW-1:0]    tcnt;
      logic [CNT_W-1:0] den;
      logic [CNT_W-1:0] img;
      logic [CNT_W-1:0] thr;
   } ent_type;

   localparam int EW = $bits(ent_type);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_PLAN   = 3'd2;
   localparam logic [2:0] S_TSCAN  = 3'd3;
   localparam logic [2:0] S_EXEC   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic                   guard_ff, guard_in;
   logic [RIGHTS_W-1:0]    mask_ff, mask_in;
   logic [TABLE_DEPTH-1:0] active_ff, active_in;
   logic [UW-1:0]          used_ff, used_in;
   logic [CNT_W-1:0]       tot_ff [4];
   logic [CNT_W-1:0]       tot_in [4];
   logic                   out_vld_ff, out_vld_in;
   rsp_type                out_ff, out_in;

   logic [UW-1:0]  iss_ff, iss_in;
   logic           cvld_ff, cvld_in;
   logic [SW-1:0]  cidx_ff, cidx_in;
   logic           found_ff, found_in;
   logic [SW-1:0]  slot_ff, slot_in;
   ent_type        ent_ff, ent_in;
   logic           fvld_ff, fvld_in;
   logic [SW-1:0]  free_ff, free_in;
   logic [TW-1:0]  tiss_ff, tiss_in;
   logic           tcvld_ff, tcvld_in;
   logic [TW-1:0]  tcidx_ff, tcidx_in;
   logic           tfound_ff, tfound_in;
   rsp_type        res_ff, res_in;

   logic [EW-1:0]   e_rdata;
   ent_type         e_rd;
   logic            e_we;
   logic [SW-1:0]   e_waddr;
   ent_type         e_wdata;
   logic [ID_W-1:0] t_rdata;
   logic            t_we;
   logic [TAW-1:0]  t_waddr;
   logic [ID_W-1:0] t_wdata;

   req_type    rq;
   logic       need_trust;
   logic       untrusted;
   logic [SW-1:0] ps;
   ent_type    ne;
   logic       prot;

   assign rq   = q_data.req;
   assign e_rd = ent_type'(e_rdata);

   pidf_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
      .clock  (clock),
      .wr_en  (e_we),
      .wr_addr(e_waddr),
      .wr_data(EW'(e_wdata)),
      .rd_addr(iss_ff[SW-1:0]),
      .rd_data(e_rdata)
   );

   pidf_ram #(.WIDTH(ID_W), .DEPTH(TDEPTH)) u_trust_ram (
      .clock  (clock),
      .wr_en  (t_we),
      .wr_addr(t_waddr),
      .wr_data(t_wdata),
      .rd_addr({slot_ff, tiss_ff[TIW-1:0]}),
      .rd_data(t_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      guard_in   = guard_ff;
      mask_in    = mask_ff;
      active_in  = active_ff;
      used_in    = used_ff;
      tot_in     = tot_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      out_in     = out_ff;
      iss_in     = iss_ff;
      cvld_in    = cvld_ff;
      cidx_in    = cidx_ff;
      found_in   = found_ff;
      slot_in    = slot_ff;
      ent_in     = ent_ff;
      fvld_in    = fvld_ff;
      free_in    = free_ff;
      tiss_in    = tiss_ff;
      tcvld_in   = tcvld_ff;
      tcidx_in   = tcidx_ff;
      tfound_in  = tfound_ff;
      res_in     = res_ff;
      q_pop      = 1'b0;
      e_we       = 1'b0;
      e_waddr    = slot_ff;
      e_wdata    = ent_ff;
      t_we       = 1'b0;
      t_waddr    = {slot_ff, ent_ff.tcnt[TIW-1:0]};
      t_wdata    = rq.caller_pid;
      need_trust = 1'b0;
      untrusted  = 1'b0;
      ps         = slot_ff;
      ne         = ent_ff;
      prot       = found_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cvld_in   = 1'b0;
               found_in  = 1'b0;
               fvld_in   = 1'b0;
               tfound_in = 1'b0;
               iss_in    = '0;
               state_in  = (guard_ff && used_ff != '0) ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            // read is issued in the cycle before its compare
            cvld_in = (iss_ff < used_ff);
            cidx_in = iss_ff[SW-1:0];
            if (iss_ff < used_ff) begin
               iss_in = iss_ff + UW'(1);
            end
            if (cvld_ff) begin
               if (!active_ff[cidx_ff] && !fvld_ff) begin
                  fvld_in = 1'b1;
                  free_in = cidx_ff;
               end
               if (active_ff[cidx_ff] && e_rd.pid == rq.target_pid) begin
                  found_in = 1'b1;
                  slot_in  = cidx_ff;
                  ent_in   = e_rd;
                  state_in = S_PLAN;
               end else if (UW'(cidx_ff) + UW'(1) == used_ff) begin
                  state_in = S_PLAN;
               end
            end
         end
         S_PLAN: begin
            tiss_in  = '0;
            tcvld_in = 1'b0;
            need_trust = found_ff && ((rq.func == FN_ADD_TRUST) ||
                         (rq.func == FN_MEMORY && !q_data.self_trust) ||
                         (rq.func == FN_HANDLE && !q_data.self_trust &&
                          (rq.access_rights & mask_ff) != '0));
            state_in = (need_trust && ent_ff.tcnt != '0) ? S_TSCAN : S_EXEC;
         end
         S_TSCAN: begin
            tcvld_in = (tiss_ff < ent_ff.tcnt);
            tcidx_in = tiss_ff;
            if (tiss_ff < ent_ff.tcnt) begin
               tiss_in = tiss_ff + TW'(1);
            end
            if (tcvld_ff) begin
               if (t_rdata == rq.caller_pid) begin
                  tfound_in = 1'b1;
                  state_in  = S_EXEC;
               end else if (tcidx_ff + TW'(1) == ent_ff.tcnt) begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            res_in.status = ST_OK;
            untrusted = !q_data.self_trust && !tfound_ff;
            if (!guard_ff) begin
               res_in.status = (rq.func <= FN_ADD_TRUST) ? ST_ERROR : ST_OK;
               prot = 1'b0;
            end else begin
               case (rq.func)
                  FN_PROTECT: begin
                     if (q_data.tgt_zero) begin
                        res_in.status = ST_ERROR;
                     end else if (!found_ff) begin
                        if (fvld_ff) begin
                           ps = free_ff;
                        end else begin
                           ps = used_ff[SW-1:0];
                        end
                        if (!fvld_ff && used_ff >= UW'(TABLE_DEPTH)) begin
                           res_in.status = ST_ERROR;
                        end else begin
                           if (!fvld_ff) begin
                              used_in = used_ff + UW'(1);
                           end
                           ne        = '0;
                           ne.pid    = rq.target_pid;
                           e_we      = 1'b1;
                           e_waddr   = ps;
                           e_wdata   = ne;
                           active_in[ps] = 1'b1;
                           prot      = 1'b1;
                        end
                     end
                  end
                  FN_UNPROTECT, FN_EXIT: begin
                     if (found_ff) begin
                        active_in[slot_ff] = 1'b0;
                     end else if (rq.func == FN_UNPROTECT) begin
                        res_in.status = ST_ERROR;
                     end
                     prot = 1'b0;
                  end
                  FN_ADD_TRUST: begin
                     if (!found_ff) begin
                        res_in.status = ST_ERROR;
                     end else if (!tfound_ff) begin
                        if (ent_ff.tcnt >= TW'(TRUST_DEPTH)) begin
                           res_in.status = ST_ERROR;
                        end else begin
                           t_we    = 1'b1;
                           ne.tcnt = ent_ff.tcnt + TW'(1);
                           e_we    = 1'b1;
                           e_wdata = ne;
                        end
                     end
                  end
                  FN_HANDLE: begin
                     tot_in[0] = tot_ff[0] + CNT_W'(1);
                     if (found_ff && untrusted && (rq.access_rights & mask_ff) != '0) begin
                        ne.den    = ent_ff.den + CNT_W'(1);
                        e_we      = 1'b1;
                        e_wdata   = ne;
                        tot_in[1] = tot_ff[1] + CNT_W'(1);
                        res_in.status = ST_DENIED;
                     end
                  end
                  FN_MEMORY: begin
                     tot_in[2] = tot_ff[2] + CNT_W'(1);
                     if (found_ff && untrusted) begin
                        ne.den    = ent_ff.den + CNT_W'(1);
                        e_we      = 1'b1;
                        e_wdata   = ne;
                        tot_in[3] = tot_ff[3] + CNT_W'(1);
                        res_in.status = ST_DENIED;
                     end
                  end
                  FN_THREAD: begin
                     if (found_ff) begin
                        ne.thr  = ent_ff.thr + CNT_W'(1);
                        e_we    = 1'b1;
                        e_wdata = ne;
                     end
                  end
                  FN_IMAGE: begin
                     if (found_ff) begin
                        ne.img  = ent_ff.img + CNT_W'(1);
                        e_we    = 1'b1;
                        e_wdata = ne;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            res_in.target_protected    = prot;
            res_in.entry_slot          = prot ? 8'(ps) : 8'd0;
            res_in.entry_denied        = prot ? ne.den : '0;
            res_in.entry_images        = prot ? ne.img : '0;
            res_in.entry_threads       = prot ? ne.thr : '0;
            res_in.total_handle_checks = tot_in[0];
            res_in.total_handle_denied = tot_in[1];
            res_in.mem_checks_total    = tot_in[2];
            res_in.mem_denied_total    = tot_in[3];
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!out_vld_ff || !rsp_stall) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               q_pop      = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         case (csr_index)
            CSR_GUARD: begin
               guard_in = csr_wdata[0];
               // re-arming wipes the table and totals
               if (!guard_ff && csr_wdata[0]) begin
                  active_in = '0;
                  used_in   = '0;
                  for (int k = 0; k < 4; k++) begin
                     tot_in[k] = '0;
                  end
               end
            end
            CSR_MASK: begin
               mask_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         guard_ff   <= 1'b1;
         mask_ff    <= MASK_RESET;
         active_ff  <= '0;
         used_ff    <= '0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            tot_ff[k] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         guard_ff   <= guard_in;
         mask_ff    <= mask_in;
         active_ff  <= active_in;
         used_ff    <= used_in;
         out_vld_ff <= out_vld_in;
         tot_ff     <= tot_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      iss_ff    <= iss_in;
      cvld_ff   <= cvld_in;
      cidx_ff   <= cidx_in;
      found_ff  <= found_in;
      slot_ff   <= slot_in;
      ent_ff    <= ent_in;
      fvld_ff   <= fvld_in;
      free_ff   <= free_in;
      tiss_ff   <= tiss_in;
      tcvld_ff  <= tcvld_in;
      tcidx_ff  <= tcidx_in;
      tfound_ff <= tfound_in;
      res_ff    <= res_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
endmodule

// ----- rtl/protected_id_access_filter.sv -----
// Protected-ID access filter.
// Requests enter on req_valid/req_stall/req_data; a request is taken on a
// clock edge with req_valid high and req_stall low. Each request gives
// exactly one result on rsp_valid/rsp_stall/rsp_data, in order.
// A two-entry queue in the front end takes requests while the back end is
// busy; req_stall rises only when that queue is full.
// The back end walks the slot table one slot a cycle, up to the high-water
// mark, then, when a trust check is needed, the target's trust list one
// entry a cycle. One request is in the back end at a time.
// The result register holds a result while rsp_stall is high; the back end
// waits on it and the queue fills behind.
// Reset empties the queue and result register, sets guard_enable and the
// default rights mask and marks every slot free; no clearing pass runs.
// csr_write_enable/csr_index/csr_wdata write a register.
module protected_id_access_filter #(
   parameter int TABLE_DEPTH = 256,
   parameter int TRUST_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pidf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pidf_pkg::rsp_type              rsp_data,
   input  logic                           csr_write_enable,
   input  logic [pidf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pidf_pkg::RIGHTS_W-1:0]  csr_wdata
);
   import pidf_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cls_type q_data;

   pidf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop)
   );

   pidf_back #(.TABLE_DEPTH(TABLE_DEPTH), .TRUST_DEPTH(TRUST_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );
endmodule

// ----- rtl/pidf_checker.sv -----
module pidf_assert (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pidf_pkg::rsp_type rsp_data
);
   import pidf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_DENIED ||
                     rsp_data.status == ST_ERROR))
      else $error("bad status code");

   a_denied_prot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DENIED |-> rsp_data.target_protected)
      else $error("denial on unprotected target");

   a_unprot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.target_protected |->
         rsp_data.entry_slot == 8'd0 && rsp_data.entry_denied == '0 &&
         rsp_data.entry_images == '0 && rsp_data.entry_threads == '0)
      else $error("entry fields set for unprotected target");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind protected_id_access_filter pidf_assert u_pidf_assert (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
